### rtl/core/tlik_pkg.sv
// ============================================================================
// tlik_pkg: shared types and constants of the two-link leg solver
// Fixed-point widths, the queue beat layout and the CORDIC angle table.
// ============================================================================
package tlik_pkg;

    // Field and register widths.
    localparam int L_W       = 16;   // link length
    localparam int POS_W     = 18;   // target coordinate
    localparam int OUT_W     = 16;   // Q4.12 angle
    localparam int CFG_IDX_W = 2;

    // Internal arithmetic widths.
    localparam int SQ_W  = 35;       // one coordinate squared
    localparam int D2_W  = 34;       // x^2 + z^2 of a reachable target
    localparam int DSQ_W = 2 * L_W;  // (L3 - L4)^2
    localparam int SSQ_W = 34;       // (L3 + L4)^2
    localparam int L0_W  = 25;       // reach in units of 2^-24 m
    localparam int DEN_W = 42;       // 2 * L4 * l0
    localparam int NK_W  = 34;       // L4^2 - L3^2, signed
    localparam int NUM_W = 36;       // cosine numerator, signed
    localparam int MAG_W = 35;       // numerator magnitude
    localparam int REM_W = 43;       // divider remainder
    localparam int Q_W   = 21;       // cosine magnitude, Q20
    localparam int C_W   = 22;       // signed cosine, Q20
    localparam int CSQ_W = 41;       // cosine squared
    localparam int S_W   = 21;       // sine, Q20
    localparam int CW    = 42;       // CORDIC vector lanes
    localparam int ANG_W = 32;       // Q28 angle
    localparam int SUM_W = 34;       // sum of two Q28 angles

    // Queue between the front and back parts.
    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_W      = 2;
    localparam int Q_CNT_W      = 3;
    localparam int Q_BUSY_LEVEL = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LEN = 2'd1;

    localparam logic [L_W-1:0]          LINK_RESET = 16'd6554;
    localparam logic signed [ANG_W-1:0] PI_Q28     = 32'sd843314857;
    localparam logic [Q_W-1:0]          C_ONE      = 21'h100000;
    localparam logic [CSQ_W-1:0]        C_ONE_SQ   = 41'h100_0000_0000;
    localparam int                      ATAN_LEN   = 24;

    // One classified target as it waits in the queue.
    typedef struct packed {
        logic                    ok;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] z;
        logic [D2_W-1:0]         d2;
    } t_item;

    // Queue status seen by the top level.
    typedef struct packed {
        logic               empty;
        logic               full;
        logic [Q_CNT_W-1:0] count;
    } t_q_stat;

    // atan(2^-i) in Q28 radians.
    function automatic logic signed [ANG_W-1:0] atan_q28(input int unsigned idx);
        logic signed [ANG_W-1:0] v;
        unique case (idx)
            0:       v = 32'sd210828714;
            1:       v = 32'sd124459457;
            2:       v = 32'sd65760959;
            3:       v = 32'sd33381290;
            4:       v = 32'sd16755422;
            5:       v = 32'sd8385879;
            6:       v = 32'sd4193963;
            7:       v = 32'sd2097109;
            8:       v = 32'sd1048571;
            9:       v = 32'sd524287;
            10:      v = 32'sd262144;
            11:      v = 32'sd131072;
            12:      v = 32'sd65536;
            13:      v = 32'sd32768;
            14:      v = 32'sd16384;
            15:      v = 32'sd8192;
            16:      v = 32'sd4096;
            17:      v = 32'sd2048;
            18:      v = 32'sd1024;
            19:      v = 32'sd512;
            20:      v = 32'sd256;
            21:      v = 32'sd128;
            22:      v = 32'sd64;
            23:      v = 32'sd32;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/two_link_leg_inverse_kinematics.sv
// ============================================================================
// two_link_leg_inverse_kinematics: two-link leg joint angle solver
// The path runs through the bit-serial roots, the divider and the CORDIC chain.
// Throughput: one target per cycle while busy is low, fully pipelined.
// Reset clears all pipeline valids and the queue and loads both link lengths
// with 6554. Results are strobed for one cycle; the receiver cannot stall.
// ============================================================================
module two_link_leg_inverse_kinematics import tlik_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [POS_W-1:0] i_x_pos,
    input  logic signed [POS_W-1:0] i_z_pos,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [L_W-1:0]          i_cfg_data,
    output logic                    o_valid,
    output logic                    o_solved,
    output logic signed [OUT_W-1:0] o_angle_one,
    output logic signed [OUT_W-1:0] o_angle_four
);

    logic [L_W-1:0] r_upper_len;
    logic [L_W-1:0] r_lower_len;
    logic           w_accept;
    logic           w_push;
    t_item          w_item;
    t_item          w_head;
    t_q_stat        w_q_stat;

    // Link length registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_len <= LINK_RESET;
            r_lower_len <= LINK_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_UPPER_LEN) begin
                r_upper_len <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_LOWER_LEN) begin
                r_lower_len <= i_cfg_data;
            end
        end
    end

    // A beat is taken while the queue has room for those in flight.
    assign busy     = (w_q_stat.count >= Q_CNT_W'(Q_BUSY_LEVEL));
    assign w_accept = start && !busy;

    tlik_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_x_pos     (i_x_pos),
        .i_z_pos     (i_z_pos),
        .i_upper_len (r_upper_len),
        .i_lower_len (r_lower_len),
        .o_push      (w_push),
        .o_item      (w_item)
    );

    tlik_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (!w_q_stat.empty),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    tlik_back #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (!w_q_stat.empty),
        .i_item       (w_head),
        .i_upper_len  (r_upper_len),
        .i_lower_len  (r_lower_len),
        .o_valid      (o_valid),
        .o_solved     (o_solved),
        .o_angle_one  (o_angle_one),
        .o_angle_four (o_angle_four)
    );

    // An accepted beat reaches the queue on the next cycle.
    a_accept_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_push)
        else $error("accepted target did not reach the queue");

    // The queue never drops a beat.
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_stat.full))
        else $error("push into a full queue");

    // A failed target reports zero angles.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_solved) |-> (o_angle_one == '0 && o_angle_four == '0))
        else $error("failed target with nonzero angles");

endmodule

### rtl/core/tlik_front.sv
// ============================================================================
// tlik_front: target intake and reachability check
// Squares the target and tests (L3-L4)^2 < x^2+z^2 < (L3+L4)^2 and a nonzero L4 in two stages.
// ============================================================================
module tlik_front import tlik_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic signed [POS_W-1:0] i_x_pos,
    input  logic signed [POS_W-1:0] i_z_pos,
    input  logic [L_W-1:0]          i_upper_len,
    input  logic [L_W-1:0]          i_lower_len,
    output logic                    o_push,
    output t_item                   o_item
);

    logic                      r_v1;
    logic signed [POS_W-1:0]   r_x1;
    logic signed [POS_W-1:0]   r_z1;
    logic [SQ_W-1:0]           r_xx;
    logic [SQ_W-1:0]           r_zz;
    logic [DSQ_W-1:0]          r_diff_sq;
    logic [SSQ_W-1:0]          r_sum_sq;
    logic                      r_lower_zero;

    logic signed [L_W:0]       w_diff;
    logic [L_W:0]              w_sum;
    logic signed [2*L_W+1:0]   w_diff_prod;
    logic [2*L_W+1:0]          w_sum_prod;
    logic signed [2*POS_W-1:0] w_xx;
    logic signed [2*POS_W-1:0] w_zz;
    logic [SQ_W:0]             w_d2;
    logic                      w_ok;

    // Bounds derived from the link lengths, refreshed every cycle.
    assign w_diff      = $signed({1'b0, i_upper_len}) - $signed({1'b0, i_lower_len});
    assign w_sum       = {1'b0, i_upper_len} + {1'b0, i_lower_len};
    assign w_diff_prod = w_diff * w_diff;
    assign w_sum_prod  = w_sum * w_sum;

    always_ff @(posedge i_clk) begin
        r_diff_sq    <= w_diff_prod[DSQ_W-1:0];
        r_sum_sq     <= w_sum_prod[SSQ_W-1:0];
        r_lower_zero <= (i_lower_len == '0);
    end

    // First stage: square both coordinates.
    assign w_xx = i_x_pos * i_x_pos;
    assign w_zz = i_z_pos * i_z_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x1 <= i_x_pos;
        r_z1 <= i_z_pos;
        r_xx <= w_xx[SQ_W-1:0];
        r_zz <= w_zz[SQ_W-1:0];
    end

    // Second stage: add and classify, then hand the beat to the queue.
    assign w_d2 = {1'b0, r_xx} + {1'b0, r_zz};
    assign w_ok = (w_d2 > (SQ_W+1)'(r_diff_sq)) && (w_d2 < (SQ_W+1)'(r_sum_sq)) &&
                  !r_lower_zero;

    assign o_push    = r_v1;
    assign o_item.ok = w_ok;
    assign o_item.x  = r_x1;
    assign o_item.z  = r_z1;
    assign o_item.d2 = w_d2[D2_W-1:0];

endmodule

### rtl/core/tlik_queue.sv
// ============================================================================
// tlik_queue: short queue between the front and back parts
// Holds classified targets; the head is read directly from the register file.
// ============================================================================
module tlik_queue import tlik_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output t_item   o_head,
    output t_q_stat o_stat
);

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_CNT_W-1:0] n_count;
    logic               w_empty;
    logic               w_full;
    logic               w_push;
    logic               w_pop;

    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign w_push  = i_push && !w_full;
    assign w_pop   = i_pop && !w_empty;

    // Storage writes.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Fill level follows pushes and pops.
    always_comb begin
        unique case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.empty = w_empty;
    assign o_stat.full  = w_full;
    assign o_stat.count = r_count;

endmodule

### rtl/core/tlik_sqrt.sv
// ============================================================================
// tlik_sqrt: pipelined integer square root
// Floor root of a 2*RW bit radicand, one result bit per stage, with sideband.
// ============================================================================
module tlik_sqrt #(
    parameter int RW   = 25,
    parameter int SB_W = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [2*RW-1:0] i_rad,
    input  logic [SB_W-1:0] i_sb,
    output logic            o_valid,
    output logic [RW-1:0]   o_root,
    output logic [SB_W-1:0] o_sb
);

    logic            r_v    [RW];
    logic [2*RW-1:0] r_n    [RW];
    logic [RW+1:0]   r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [SB_W-1:0] r_sb   [RW];

    for (genvar k = 0; k < RW; k++) begin : g_step
        logic            s_v;
        logic [2*RW-1:0] s_n;
        logic [RW+1:0]   s_rem;
        logic [RW-1:0]   s_root;
        logic [SB_W-1:0] s_sb;
        logic [RW+3:0]   w_tmp;
        logic [RW+3:0]   w_trial;
        logic [RW+3:0]   w_diff;
        logic            w_ge;

        if (k == 0) begin : g_in
            assign s_v    = i_valid;
            assign s_n    = i_rad;
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_sb   = i_sb;
        end else begin : g_link
            assign s_v    = r_v[k-1];
            assign s_n    = r_n[k-1];
            assign s_rem  = r_rem[k-1];
            assign s_root = r_root[k-1];
            assign s_sb   = r_sb[k-1];
        end

        // Bring down two radicand bits and try the next root bit.
        assign w_tmp   = {s_rem, s_n[2*RW-1 -: 2]};
        assign w_trial = {2'b00, s_root, 2'b01};
        assign w_diff  = w_tmp - w_trial;
        assign w_ge    = (w_tmp >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_n[k]    <= {s_n[2*RW-3:0], 2'b00};
            r_rem[k]  <= w_ge ? w_diff[RW+1:0] : w_tmp[RW+1:0];
            r_root[k] <= {s_root[RW-2:0], w_ge};
            r_sb[k]   <= s_sb;
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_sb    = r_sb[RW-1];

endmodule

### rtl/core/tlik_cordic.sv
// ============================================================================
// tlik_cordic: pipelined CORDIC vectoring unit
// Returns the Q28 angle of (x, y), one micro-rotation per stage.
// ============================================================================
module tlik_cordic import tlik_pkg::*; #(
    parameter int STAGES = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [CW-1:0]    i_x,
    input  logic signed [CW-1:0]    i_y,
    output logic                    o_valid,
    output logic signed [ANG_W-1:0] o_angle
);

    logic                    r_v [STAGES+1];
    logic signed [CW-1:0]    r_x [STAGES+1];
    logic signed [CW-1:0]    r_y [STAGES+1];
    logic signed [ANG_W-1:0] r_a [STAGES+1];

    // Pre-rotation by pi for the left half plane.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_x < 0) begin
            r_x[0] <= -i_x;
            r_y[0] <= -i_y;
            r_a[0] <= (i_y >= 0) ? PI_Q28 : -PI_Q28;
        end else begin
            r_x[0] <= i_x;
            r_y[0] <= i_y;
            r_a[0] <= '0;
        end
    end

    // Micro-rotations that drive y toward zero.
    for (genvar k = 0; k < STAGES; k++) begin : g_rot
        logic signed [CW-1:0] w_xs;
        logic signed [CW-1:0] w_ys;

        assign w_xs = r_x[k] >>> k;
        assign w_ys = r_y[k] >>> k;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (r_y[k] > 0) begin
                r_x[k+1] <= r_x[k] + w_ys;
                r_y[k+1] <= r_y[k] - w_xs;
                r_a[k+1] <= r_a[k] + atan_q28(k);
            end else begin
                r_x[k+1] <= r_x[k] - w_ys;
                r_y[k+1] <= r_y[k] + w_xs;
                r_a[k+1] <= r_a[k] - atan_q28(k);
            end
        end
    end

    assign o_valid = r_v[STAGES];
    assign o_angle = r_a[STAGES];

endmodule

### rtl/core/tlik_back.sv
// ============================================================================
// tlik_back: solver pipeline for classified targets
// Reach root, cosine division, sine root, two CORDIC angles and rounding.
// ============================================================================
module tlik_back import tlik_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_item                   i_item,
    input  logic [L_W-1:0]          i_upper_len,
    input  logic [L_W-1:0]          i_lower_len,
    output logic                    o_valid,
    output logic                    o_solved,
    output logic signed [OUT_W-1:0] o_angle_one,
    output logic signed [OUT_W-1:0] o_angle_four
);

    typedef struct packed {
        logic                    ok;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] z;
        logic signed [C_W-1:0]   c;
    } t_cos_sb;

    localparam int ITEM_W = $bits(t_item);
    localparam int CSB_W  = $bits(t_cos_sb);
    localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(32768);

    // Saturating round of a Q28 angle to Q4.12.
    function automatic logic signed [OUT_W-1:0] to_q12(input logic signed [SUM_W-1:0] a);
        logic signed [SUM_W-1:0]  t;
        logic signed [SUM_W-17:0] r;
        logic signed [OUT_W-1:0]  q;
        t = a + HALF_LSB;
        r = t[SUM_W-1:16];
        if (r > (SUM_W-16)'(32767)) begin
            q = 16'sh7FFF;
        end else if (r < -(SUM_W-16)'(32768)) begin
            q = 16'sh8000;
        end else begin
            q = r[OUT_W-1:0];
        end
        return q;
    endfunction

    // L4^2 - L3^2 from the link lengths.
    logic signed [L_W:0]     w_nk_a;
    logic signed [L_W+1:0]   w_nk_b;
    logic signed [2*L_W+2:0] w_nk_p;
    logic signed [NK_W-1:0]  r_nk;

    assign w_nk_a = $signed({1'b0, i_lower_len}) - $signed({1'b0, i_upper_len});
    assign w_nk_b = $signed({2'b00, i_lower_len}) + $signed({2'b00, i_upper_len});
    assign w_nk_p = w_nk_a * w_nk_b;

    always_ff @(posedge i_clk) begin
        r_nk <= w_nk_p[NK_W-1:0];
    end

    // Reach l0 = floor(sqrt(d2 * 2^16)).
    logic              w_s1_v;
    logic [L0_W-1:0]   w_s1_root;
    logic [ITEM_W-1:0] w_s1_bits;
    t_item             w_s1;

    tlik_sqrt #(
        .RW   (L0_W),
        .SB_W (ITEM_W)
    ) u_reach_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_rad   ({i_item.d2, 16'h0000}),
        .i_sb    (i_item),
        .o_valid (w_s1_v),
        .o_root  (w_s1_root),
        .o_sb    (w_s1_bits)
    );

    assign w_s1 = t_item'(w_s1_bits);

    // Numerator and denominator of the cosine.
    logic [L_W+L0_W-1:0]     w_den_p;
    logic signed [NUM_W-1:0] w_num;
    logic                    r_b1_v;
    logic                    r_b1_ok;
    logic signed [POS_W-1:0] r_b1_x;
    logic signed [POS_W-1:0] r_b1_z;
    logic [DEN_W-1:0]        r_b1_den;
    logic signed [NUM_W-1:0] r_b1_num;

    assign w_den_p = i_lower_len * w_s1_root;
    assign w_num   = $signed({2'b00, w_s1.d2}) + NUM_W'(r_nk);

    always_ff @(posedge i_clk) begin
        r_b1_ok  <= w_s1.ok;
        r_b1_x   <= w_s1.x;
        r_b1_z   <= w_s1.z;
        r_b1_den <= {w_den_p, 1'b0};
        r_b1_num <= w_num;
    end

    // Magnitude and sign of the numerator.
    logic signed [NUM_W-1:0] w_abs;
    logic                    r_b2_v;
    logic                    r_b2_ok;
    logic signed [POS_W-1:0] r_b2_x;
    logic signed [POS_W-1:0] r_b2_z;
    logic [DEN_W-1:0]        r_b2_den;
    logic [MAG_W-1:0]        r_b2_mag;
    logic                    r_b2_neg;

    assign w_abs = r_b1_num[NUM_W-1] ? -r_b1_num : r_b1_num;

    always_ff @(posedge i_clk) begin
        r_b2_ok  <= r_b1_ok;
        r_b2_x   <= r_b1_x;
        r_b2_z   <= r_b1_z;
        r_b2_den <= r_b1_den;
        r_b2_mag <= w_abs[MAG_W-1:0];
        r_b2_neg <= r_b1_num[NUM_W-1];
    end

    // Overflow test: a quotient of 2^21 or more is clamped anyway.
    logic [REM_W-1:0]        w_rem0;
    logic                    r_b3_v;
    logic                    r_b3_ok;
    logic signed [POS_W-1:0] r_b3_x;
    logic signed [POS_W-1:0] r_b3_z;
    logic [DEN_W-1:0]        r_b3_den;
    logic [REM_W-1:0]        r_b3_rem;
    logic                    r_b3_neg;
    logic                    r_b3_ovf;

    assign w_rem0 = REM_W'({r_b2_mag, 7'b0000000});

    always_ff @(posedge i_clk) begin
        r_b3_ok  <= r_b2_ok;
        r_b3_x   <= r_b2_x;
        r_b3_z   <= r_b2_z;
        r_b3_den <= r_b2_den;
        r_b3_rem <= w_rem0;
        r_b3_neg <= r_b2_neg;
        r_b3_ovf <= (w_rem0 >= REM_W'(r_b2_den));
    end

    // Restoring division, one quotient bit per stage.
    logic                    r_d_v   [Q_W];
    logic                    r_d_ok  [Q_W];
    logic signed [POS_W-1:0] r_d_x   [Q_W];
    logic signed [POS_W-1:0] r_d_z   [Q_W];
    logic [DEN_W-1:0]        r_d_den [Q_W];
    logic [REM_W-1:0]        r_d_rem [Q_W];
    logic [Q_W-1:0]          r_d_q   [Q_W];
    logic                    r_d_neg [Q_W];
    logic                    r_d_ovf [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_div
        logic                    s_v;
        logic                    s_ok;
        logic signed [POS_W-1:0] s_x;
        logic signed [POS_W-1:0] s_z;
        logic [DEN_W-1:0]        s_den;
        logic [REM_W-1:0]        s_rem;
        logic [Q_W-1:0]          s_q;
        logic                    s_neg;
        logic                    s_ovf;
        logic [REM_W-1:0]        w_sh;
        logic                    w_ge;

        if (k == 0) begin : g_in
            assign s_v   = r_b3_v;
            assign s_ok  = r_b3_ok;
            assign s_x   = r_b3_x;
            assign s_z   = r_b3_z;
            assign s_den = r_b3_den;
            assign s_rem = r_b3_rem;
            assign s_q   = '0;
            assign s_neg = r_b3_neg;
            assign s_ovf = r_b3_ovf;
        end else begin : g_link
            assign s_v   = r_d_v[k-1];
            assign s_ok  = r_d_ok[k-1];
            assign s_x   = r_d_x[k-1];
            assign s_z   = r_d_z[k-1];
            assign s_den = r_d_den[k-1];
            assign s_rem = r_d_rem[k-1];
            assign s_q   = r_d_q[k-1];
            assign s_neg = r_d_neg[k-1];
            assign s_ovf = r_d_ovf[k-1];
        end

        assign w_sh = {s_rem[REM_W-2:0], 1'b0};
        assign w_ge = (w_sh >= REM_W'(s_den));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_v[k] <= 1'b0;
            end else begin
                r_d_v[k] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_d_ok[k]  <= s_ok;
            r_d_x[k]   <= s_x;
            r_d_z[k]   <= s_z;
            r_d_den[k] <= s_den;
            r_d_rem[k] <= w_ge ? (w_sh - REM_W'(s_den)) : w_sh;
            r_d_q[k]   <= {s_q[Q_W-2:0], w_ge};
            r_d_neg[k] <= s_neg;
            r_d_ovf[k] <= s_ovf;
        end
    end

    // Clamp the cosine to [-1, 1] and square it.
    logic [Q_W-1:0]          w_cmag;
    logic [2*Q_W-1:0]        w_csq;
    logic                    r_c1_v;
    logic                    r_c1_ok;
    logic signed [POS_W-1:0] r_c1_x;
    logic signed [POS_W-1:0] r_c1_z;
    logic signed [C_W-1:0]   r_c1_c;
    logic [CSQ_W-1:0]        r_c1_csq;

    assign w_cmag = (r_d_ovf[Q_W-1] || (r_d_q[Q_W-1] > C_ONE)) ? C_ONE : r_d_q[Q_W-1];
    assign w_csq  = w_cmag * w_cmag;

    always_ff @(posedge i_clk) begin
        r_c1_ok  <= r_d_ok[Q_W-1];
        r_c1_x   <= r_d_x[Q_W-1];
        r_c1_z   <= r_d_z[Q_W-1];
        r_c1_c   <= r_d_neg[Q_W-1] ? -$signed({1'b0, w_cmag}) : $signed({1'b0, w_cmag});
        r_c1_csq <= w_csq[CSQ_W-1:0];
    end

    // Radicand of the sine.
    logic                    r_c2_v;
    logic [CSQ_W-1:0]        r_c2_rad;
    t_cos_sb                 r_c2_sb;

    always_ff @(posedge i_clk) begin
        r_c2_rad   <= C_ONE_SQ - r_c1_csq;
        r_c2_sb.ok <= r_c1_ok;
        r_c2_sb.x  <= r_c1_x;
        r_c2_sb.z  <= r_c1_z;
        r_c2_sb.c  <= r_c1_c;
    end

    // Stage valids of the arithmetic stages above.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
            r_b3_v <= 1'b0;
            r_c1_v <= 1'b0;
            r_c2_v <= 1'b0;
        end else begin
            r_b1_v <= w_s1_v;
            r_b2_v <= r_b1_v;
            r_b3_v <= r_b2_v;
            r_c1_v <= r_d_v[Q_W-1];
            r_c2_v <= r_c1_v;
        end
    end

    // Sine s = floor(sqrt(2^40 - c^2)).
    logic              w_s2_v;
    logic [S_W-1:0]    w_s2_root;
    logic [CSB_W-1:0]  w_s2_bits;
    t_cos_sb           w_s2;

    tlik_sqrt #(
        .RW   (S_W),
        .SB_W (CSB_W)
    ) u_sine_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_c2_v),
        .i_rad   ({1'b0, r_c2_rad}),
        .i_sb    (r_c2_sb),
        .o_valid (w_s2_v),
        .o_root  (w_s2_root),
        .o_sb    (w_s2_bits)
    );

    assign w_s2 = t_cos_sb'(w_s2_bits);

    // Inner angle atan2(s, c) and direction atan2(z, x) side by side.
    logic signed [CW-1:0]    w_in_x;
    logic signed [CW-1:0]    w_in_y;
    logic signed [CW-1:0]    w_dir_x;
    logic signed [CW-1:0]    w_dir_y;
    logic                    w_in_v;
    logic                    w_dir_v;
    logic signed [ANG_W-1:0] w_inner;
    logic signed [ANG_W-1:0] w_dir;

    assign w_in_x  = CW'(w_s2.c) <<< 16;
    assign w_in_y  = $signed(CW'({w_s2_root, 16'h0000}));
    assign w_dir_x = CW'(w_s2.x) <<< 20;
    assign w_dir_y = CW'(w_s2.z) <<< 20;

    tlik_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_inner_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s2_v),
        .i_x     (w_in_x),
        .i_y     (w_in_y),
        .o_valid (w_in_v),
        .o_angle (w_inner)
    );

    tlik_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_dir_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s2_v),
        .i_x     (w_dir_x),
        .i_y     (w_dir_y),
        .o_valid (w_dir_v),
        .o_angle (w_dir)
    );

    // Reach flag travels alongside the CORDIC stages.
    logic r_ok_line [CORDIC_STAGES+1];

    always_ff @(posedge i_clk) begin
        r_ok_line[0] <= w_s2.ok;
    end

    for (genvar k = 1; k <= CORDIC_STAGES; k++) begin : g_ok
        always_ff @(posedge i_clk) begin
            r_ok_line[k] <= r_ok_line[k-1];
        end
    end

    // Result register: sum, difference, round and saturate.
    logic signed [SUM_W-1:0] w_one;
    logic signed [SUM_W-1:0] w_four;
    logic                    w_ok;
    logic                    r_valid;
    logic                    r_solved;
    logic signed [OUT_W-1:0] r_angle_one;
    logic signed [OUT_W-1:0] r_angle_four;

    assign w_one  = SUM_W'(w_dir) + SUM_W'(w_inner);
    assign w_four = SUM_W'(w_dir) - SUM_W'(w_inner);
    assign w_ok   = r_ok_line[CORDIC_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_in_v && w_dir_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_solved     <= w_ok;
        r_angle_one  <= w_ok ? to_q12(w_one) : '0;
        r_angle_four <= w_ok ? to_q12(w_four) : '0;
    end

    assign o_valid      = r_valid;
    assign o_solved     = r_solved;
    assign o_angle_one  = r_angle_one;
    assign o_angle_four = r_angle_four;

endmodule

### tb/sv/tb_two_link_leg_inverse_kinematics.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_two_link_leg_inverse_kinematics: regression bench of the leg solver
// Drives foot targets through the command port under several link settings,
// predicts each solved flag and joint angle pair in fixed point, and checks
// every strobed result beat against the oldest prediction.
// ============================================================================
module tb_two_link_leg_inverse_kinematics import tlik_pkg::*; ();

    localparam int            LATENCY    = 92;
    localparam int            CYCLE_CAP  = 400000;
    localparam int            STAGES     = 16;
    localparam logic [1:0]    IDX_SPARE2 = 2'd2;
    localparam logic [1:0]    IDX_SPARE3 = 2'd3;
    localparam longint        PI_ANGLE   = 64'sd843314857;

    typedef struct {
        logic              solved;
        logic signed [15:0] angle_one;
        logic signed [15:0] angle_four;
    } t_joint_angles;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic signed [POS_W-1:0] i_x_pos;
    logic signed [POS_W-1:0] i_z_pos;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [L_W-1:0]          i_cfg_data;
    logic                    o_valid;
    logic                    o_solved;
    logic signed [OUT_W-1:0] o_angle_one;
    logic signed [OUT_W-1:0] o_angle_four;

    t_joint_angles pending_angles[$];
    logic [15:0]   upper_len;
    logic [15:0]   lower_len;
    int            idle_pct;
    int            mismatches;
    int            cycles;

    two_link_leg_inverse_kinematics #(.CORDIC_STAGES(STAGES)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_x_pos(i_x_pos), .i_z_pos(i_z_pos), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data), .o_valid(o_valid),
        .o_solved(o_solved), .o_angle_one(o_angle_one), .o_angle_four(o_angle_four)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Integer floor square root, bit by bit.
    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Vectoring CORDIC: angle of (x, y) in Q28 radians.
    function automatic longint vector_angle(longint y, longint x);
        longint ang;
        longint xs;
        longint ys;
        ang = 0;
        if (x < 0) begin
            ang = (y >= 0) ? PI_ANGLE : -PI_ANGLE;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x   = x + ys;
                y   = y - xs;
                ang = ang + longint'(atan_q28(i));
            end else begin
                x   = x - ys;
                y   = y + xs;
                ang = ang - longint'(atan_q28(i));
            end
        end
        return ang;
    endfunction

    // Round a Q28 angle to Q4.12 with saturation.
    function automatic logic signed [15:0] round_q12(longint a);
        longint r;
        r = (a + (64'sd1 << 15)) >>> 16;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    // Joint angles of one target under the current link lengths.
    function automatic t_joint_angles solve_leg(logic signed [17:0] xp, logic signed [17:0] zp);
        t_joint_angles   res;
        longint          x, z, l3, l4, d2, diff, sum, num, den, c, s, dir, inner;
        longint unsigned l0f;
        res = '{1'b0, 16'sd0, 16'sd0};
        x  = xp;
        z  = zp;
        l3 = upper_len;
        l4 = lower_len;
        d2 = x * x + z * z;
        diff = l3 - l4;
        sum  = l3 + l4;
        if (!(d2 > diff * diff && d2 < sum * sum) || l4 == 0) return res;
        l0f = floor_root(longint'(d2) << 16);
        num = l4 * l4 + d2 - l3 * l3;
        den = 2 * l4 * longint'(l0f);
        if (den <= 0) return res;
        c = (num * (64'sd1 << 28)) / den;
        if (c > (64'sd1 << 20)) c = 64'sd1 << 20;
        if (c < -(64'sd1 << 20)) c = -(64'sd1 << 20);
        s = longint'(floor_root(longint'((64'sd1 << 40) - c * c)));
        inner = vector_angle(s * (64'sd1 << 16), c * (64'sd1 << 16));
        dir   = vector_angle(z * (64'sd1 << 20), x * (64'sd1 << 20));
        res.solved     = 1'b1;
        res.angle_one  = round_q12(dir + inner);
        res.angle_four = round_q12(dir - inner);
        return res;
    endfunction

    // Send one target beat, sometimes with a random gap ahead of it.
    task automatic send_target(logic signed [17:0] xp, logic signed [17:0] zp);
        int gap;
        @(negedge i_clk);
        if ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        start   = 1'b1;
        i_x_pos = xp;
        i_z_pos = zp;
        do @(posedge i_clk); while (busy);
        pending_angles.push_back(solve_leg(xp, zp));
    endtask

    // Lower start and wait until every predicted beat has come back.
    task automatic drain_results();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_angles.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Register write; only done with the pipeline empty.
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        drain_results();
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_UPPER_LEN) upper_len = val;
        else if (idx == CFG_LOWER_LEN) lower_len = val;
    endtask

    task automatic set_links(logic [15:0] l3, logic [15:0] l4);
        write_reg(CFG_UPPER_LEN, l3);
        write_reg(CFG_LOWER_LEN, l4);
    endtask

    // Origin, coordinate extremes, the pi wrap and the reach boundaries.
    task automatic test_directed_points();
        send_target(18'sd0, 18'sd0);
        send_target(18'sd131071, 18'sd131071);
        send_target(-18'sd131072, -18'sd131072);
        send_target(-18'sd6000, 18'sd0);
        send_target(-18'sd6000, 18'sd100);
        send_target(-18'sd6000, -18'sd100);
        send_target(18'sd6000, 18'sd0);
        send_target(18'sd0, 18'sd6000);
        send_target(18'sd0, -18'sd6000);
        send_target(18'sd13107, 18'sd0);
        send_target(18'sd13108, 18'sd0);
        send_target(18'sd1, 18'sd0);
    endtask

    // A zero link length makes every target fail.
    task automatic test_zero_links();
        set_links(16'd0, 16'd6554);
        send_target(18'sd3000, 18'sd3000);
        send_target(18'sd6554, 18'sd0);
        set_links(16'd6554, 16'd0);
        send_target(18'sd3000, -18'sd3000);
        send_target(18'sd6554, 18'sd0);
    endtask

    // Writes to unused indexes must leave both lengths alone.
    task automatic test_spare_index();
        set_links(16'd6554, 16'd6554);
        write_reg(IDX_SPARE2, 16'hFFFF);
        write_reg(IDX_SPARE3, 16'd1);
        send_target(18'sd5000, 18'sd2000);
        send_target(-18'sd4000, -18'sd7000);
    endtask

    // Largest links, with targets just inside and just past the largest reach.
    task automatic test_long_links();
        set_links(16'hFFFF, 16'hFFFF);
        send_target(18'sd131069, 18'sd0);
        send_target(-18'sd131072, 18'sd0);
        send_target(18'sd0, -18'sd131072);
        send_target(-18'sd90000, 18'sd90000);
    endtask

    function automatic logic signed [17:0] pick_coord(int span);
        if (span > 131071) span = 131071;
        return 18'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    // Random targets: mostly inside the reach box, some over the full range.
    task automatic test_random_targets(int count, logic [15:0] l3, logic [15:0] l4);
        int span;
        set_links(l3, l4);
        span = int'(l3) + int'(l4) + 16;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 75)
                send_target(pick_coord(span), pick_coord(span));
            else
                send_target(18'($urandom), 18'($urandom));
        end
    endtask

    // Result checker: each strobed beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_joint_angles want;
        if (i_rst_n && o_valid) begin
            if (pending_angles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: solved %0b angles %0d %0d",
                             o_solved, o_angle_one, o_angle_four);
            end else begin
                want = pending_angles.pop_front();
                if (o_solved !== want.solved || o_angle_one !== want.angle_one ||
                    o_angle_four !== want.angle_four) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0b %0d %0d, got %0b %0d %0d",
                                 want.solved, want.angle_one, want.angle_four,
                                 o_solved, o_angle_one, o_angle_four);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("two_link_leg_inverse_kinematics regression: fail");
            $finish;
        end
    end

    initial begin
        start      = 1'b0;
        i_x_pos    = '0;
        i_z_pos    = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;
        upper_len  = LINK_RESET;
        lower_len  = LINK_RESET;
        mismatches = 0;
        cycles     = 0;
        idle_pct   = 30;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_points();
        test_zero_links();
        test_spare_index();
        test_long_links();

        idle_pct = 30;
        test_random_targets(80, 16'd6554, 16'd6554);
        test_random_targets(70, 16'd1, 16'hFFFF);
        idle_pct = 82;
        test_random_targets(80, 16'd40000, 16'd20000);
        test_random_targets(70, 16'd1, 16'd1);
        idle_pct = 0;
        test_random_targets(80, 16'hFFFF, 16'hFFFF);
        test_random_targets(70, 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));

        drain_results();
        repeat (LATENCY + 20) @(posedge i_clk);
        if (mismatches == 0 && pending_angles.size() == 0)
            $display("two_link_leg_inverse_kinematics regression: pass");
        else
            $display("two_link_leg_inverse_kinematics regression: fail");
        $finish;
    end

endmodule
